[hdl/swam_pkg.sv]
// ----------------------------------------------------------------------------
// swam_pkg
// Shared constants for the sliding window anagram match core.
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int KIND_W          = 2;
    localparam int LETTER_W        = 5;

    localparam int ALPHABET_DEF    = 26;
    localparam int MAX_PATTERN_DEF = 256;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [LETTER_W-1:0] t_letter;

endpackage

[hdl/sliding_window_anagram_match_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_anagram_match_core
// Flags text windows that are a permutation of a previously loaded pattern.
//
//   channel   direction  handshake          fields
//   input     in         i_valid / o_stall  i_kind, i_letter
//   result    out        o_valid / i_stall  o_window_match, o_found,
//                                           o_pattern_overflow
//
// One beat per cycle unless stalled; the result register loads as the beat is taken.
// Per-letter count differences live in a row of cells; the history ring is a
// RAM read ahead from the next pointer into a register, with write bypass.
// Only text letters produce a result. Reset (sync, active low) clears all
// control state; a clear beat does the same but leaves the output valid.
// The input stalls only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module sliding_window_anagram_match_core #(
    parameter int ALPHABET    = swam_pkg::ALPHABET_DEF,
    parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  swam_pkg::t_kind   i_kind,
    input  swam_pkg::t_letter i_letter,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_window_match,
    output logic              o_found,
    output logic              o_pattern_overflow
);
    import swam_pkg::*;

    localparam int CW    = $clog2(MAX_PATTERN + 1);
    localparam int DW    = CW + 1;
    localparam int LW    = CW + 1;
    localparam int PW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int AW1   = $clog2(ALPHABET + 1);
    localparam int CMP_W = (AW1 > LETTER_W) ? AW1 : LETTER_W;

    logic                 r_out_valid;
    logic                 r_out_match;
    logic                 r_out_found;
    logic                 r_out_ovf;

    logic [CW-1:0]        r_plen, n_plen;
    logic [CW-1:0]        r_fill, n_fill;
    logic [PW-1:0]        r_ptr, n_ptr;
    logic                 r_found, n_found;
    logic                 r_text_started, n_text_started;
    logic                 r_ovf, n_ovf;

    logic signed [DW-1:0] r_d [ALPHABET];
    logic signed [DW-1:0] n_d [ALPHABET];
    logic [ALPHABET-1:0]  n_eq;

    logic [LETTER_W-1:0]  ring [MAX_PATTERN];
    logic [LETTER_W-1:0]  r_old;
    logic [PW-1:0]        rd_addr;
    logic [LW-1:0]        rd_sum;

    logic                 w_accept;
    logic                 w_letter_ok;
    logic                 w_clear;
    logic                 w_pat_upd;
    logic                 w_text;
    logic                 w_text_upd;
    logic                 w_remove;
    logic                 w_match;
    logic [CMP_W-1:0]     w_letter_x;
    logic [CMP_W-1:0]     w_old_x;

    assign o_stall            = r_out_valid & i_stall;
    assign o_valid            = r_out_valid;
    assign o_window_match     = r_out_match;
    assign o_found            = r_out_found;
    assign o_pattern_overflow = r_out_ovf;

    assign w_accept    = i_valid & ~o_stall;
    assign w_letter_x  = CMP_W'(i_letter);
    assign w_old_x     = CMP_W'(r_old);
    assign w_letter_ok = w_letter_x < CMP_W'(ALPHABET);

    always_comb begin
        n_plen         = r_plen;
        n_fill         = r_fill;
        n_ptr          = r_ptr;
        n_text_started = r_text_started;
        n_ovf          = r_ovf;
        w_clear        = 1'b0;
        w_pat_upd      = 1'b0;
        w_text         = 1'b0;
        w_text_upd     = 1'b0;
        w_remove       = 1'b0;
        if (w_accept) begin
            if (i_kind == KIND_CLEAR) begin
                w_clear        = 1'b1;
                n_plen         = '0;
                n_fill         = '0;
                n_ptr          = '0;
                n_text_started = 1'b0;
                n_ovf          = 1'b0;
            end else if (i_kind == KIND_PATTERN && w_letter_ok && !r_text_started) begin
                if (r_plen >= CW'(MAX_PATTERN)) begin
                    n_ovf = 1'b1;
                end else begin
                    w_pat_upd = 1'b1;
                    n_plen    = r_plen + CW'(1);
                end
            end else if (i_kind == KIND_TEXT && w_letter_ok) begin
                w_text         = 1'b1;
                n_text_started = 1'b1;
                if (r_plen != '0) begin
                    w_text_upd = 1'b1;
                    if (r_fill >= r_plen) begin
                        w_remove = 1'b1;
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                    n_ptr = (r_ptr == PW'(MAX_PATTERN - 1)) ? '0 : r_ptr + PW'(1);
                end
            end
        end
    end

    // per-letter difference cells: window count minus pattern count
    for (genvar gi = 0; gi < ALPHABET; gi++) begin : g_cell
        logic w_inc;
        logic w_dec;
        assign w_inc = w_text_upd && (w_letter_x == CMP_W'(gi));
        assign w_dec = (w_remove && (w_old_x == CMP_W'(gi)))
                     || (w_pat_upd && (w_letter_x == CMP_W'(gi)));
        always_comb begin
            if (w_clear) begin
                n_d[gi] = '0;
            end else begin
                case ({w_inc, w_dec})
                    2'b10:   n_d[gi] = r_d[gi] + DW'(1);
                    2'b01:   n_d[gi] = r_d[gi] - DW'(1);
                    default: n_d[gi] = r_d[gi];
                endcase
            end
        end
        assign n_eq[gi] = (n_d[gi] == '0);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[gi] <= '0;
            end else begin
                r_d[gi] <= n_d[gi];
            end
        end
    end

    assign w_match = &n_eq;
    assign n_found = w_clear ? 1'b0 : (r_found | (w_text & w_match));

    // ring read address: letter that leaves with the next text beat
    always_comb begin
        rd_sum = LW'(n_ptr) + LW'(MAX_PATTERN) - LW'(n_plen);
        if (rd_sum >= LW'(MAX_PATTERN)) begin
            rd_sum = rd_sum - LW'(MAX_PATTERN);
        end
        rd_addr = rd_sum[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_text_upd) begin
            ring[r_ptr] <= i_letter;
        end
        if (w_text_upd && (r_ptr == rd_addr)) begin
            r_old <= i_letter;
        end else begin
            r_old <= ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen         <= '0;
            r_fill         <= '0;
            r_ptr          <= '0;
            r_found        <= 1'b0;
            r_text_started <= 1'b0;
            r_ovf          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_plen         <= n_plen;
            r_fill         <= n_fill;
            r_ptr          <= n_ptr;
            r_found        <= n_found;
            r_text_started <= n_text_started;
            r_ovf          <= n_ovf;
            if (w_text) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_text) begin
            r_out_match <= w_match;
            r_out_found <= n_found;
            r_out_ovf   <= r_ovf;
        end
    end

    a_fill_le_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_plen)
        else $error("window fill exceeds pattern length");

    a_plen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= CW'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_plen == CW'(MAX_PATTERN)))
        else $error("overflow flagged with pattern not full");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_CLEAR) |=>
        (r_plen == '0 && r_fill == '0 && !r_text_started && !r_found))
        else $error("clear beat left state behind");

    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_window_match) |-> o_found)
        else $error("match without found");

endmodule
